// ===== rtl/scsl_pkg.sv =====
package scsl_pkg;

    localparam int AVG_DEPTH   = 4;
    localparam int JOINT_COUNT = 3;
    localparam int JOINT_MAX   = 3;

    localparam int RING_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = 16 + $clog2(AVG_DEPTH + 1);

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;

    localparam logic [JOINT_MAX-1:0] JOINT_MASK = JOINT_MAX'((1 << JOINT_COUNT) - 1);

    typedef enum logic [0:0] {
        REQ_TICK  = 1'b0,
        REQ_LIMIT = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        REG_SCALE    = 3'd0,
        REG_MID      = 3'd1,
        REG_RANGE    = 3'd2,
        REG_SIGN     = 3'd3,
        REG_SHIFT    = 3'd4,
        REG_FREEFALL = 3'd5,
        REG_TIMEOUT  = 3'd6
    } cfg_reg_t;

    // per-joint settings handed to the compare unit
    typedef struct packed {
        logic [15:0] scale;
        logic [15:0] mid;
        logic [15:0] range;
        logic        negate;
        logic [4:0]  shift;
    } joint_cfg_t;

    typedef struct packed {
        req_type_t          req_type;
        logic               running;
        logic               lower_switch_level;
        logic               seg_load;
        logic [15:0]        seg_start;
        logic [15:0]        seg_finish;
        logic signed [15:0] pos_joint0;
        logic signed [15:0] pos_joint1;
        logic signed [15:0] pos_joint2;
    } item_t;

endpackage

// ===== rtl/scsl_joint.sv =====
module scsl_joint
    import scsl_pkg::*;
(
    input  logic signed [15:0] pos,
    input  joint_cfg_t         cfg,
    output logic [15:0]        compare
);

    logic signed [16:0] scale_s;
    logic signed [32:0] product;
    logic signed [32:0] shifted;
    logic [15:0]        cut;
    logic signed [16:0] value;
    logic signed [16:0] limit;
    logic signed [16:0] clamped;

    assign scale_s = signed'({1'b0, cfg.scale});
    assign product = 33'(pos) * 33'(scale_s);
    // arithmetic shift floors toward minus infinity
    assign shifted = product >>> cfg.shift;

    always_comb
    begin
        cut = cfg.negate ? 16'(-shifted[15:0]) : shifted[15:0];
        value = 17'(signed'(cut));
        limit = signed'({1'b0, cfg.range});
        if (value > limit)
        begin
            clamped = limit;
        end
        else if (value < -limit)
        begin
            clamped = -limit;
        end
        else
        begin
            clamped = value;
        end
        compare = cfg.mid + clamped[15:0];
    end

endmodule

// ===== rtl/servo_compare_smoother_with_limit_lock.sv =====
// Servo compare smoother with lower-limit lock.
// Slave stream s_*: one beat per request. s_tuser is the request kind (timer
// tick or lower-limit edge); s_tdata carries the mode flags, the segment bounds
// and three signed joint positions.
// Master stream m_*: exactly one result beat per request, in order: write mask,
// three compare values and the homing-done flag.
// The APB port holds the scale, midpoint and range tables, sign bits, shift,
// freefall compare and lock timeout; write it only while the stream is idle.
// An accepted beat lands in the input register; its result is then registered in
// the result register behind m_tvalid. Throughput is one beat per cycle while
// m_tready is high: the scale multiplies, clamps and the ring averages all fit
// between the input register and the result register.
// Reset clears the averaging ring, tick counters and lock (lock disarmed); the
// configuration returns to zero with a lock timeout of one.
// When m_tready is low and a result is waiting, the result register holds, the
// input register takes one more beat if it is empty, and s_tready drops after that.
module servo_compare_smoother_with_limit_lock
    import scsl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] running, [1] lower_switch_level, [2] seg_load, [18:3] seg_start,
    // [34:19] seg_finish, [50:35] pos_joint0, [66:51] pos_joint1,
    // [82:67] pos_joint2, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] write_mask, [18:3] compare_joint0, [34:19] compare_joint1,
    // [50:35] compare_joint2, [51] homing_done, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // configuration
    logic [47:0] scale_reg;
    logic [47:0] mid_reg;
    logic [47:0] range_reg;
    logic [2:0]  sign_reg;
    logic [4:0]  shift_reg;
    logic [15:0] freefall_reg;
    logic [14:0] timeout_reg;

    logic        cfg_write;
    cfg_reg_t    cfg_sel;

    // pipeline
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic        advance;

    // block state
    logic [15:0]       ring_reg [AVG_DEPTH][JOINT_COUNT];
    logic [RING_W-1:0] ring_idx_reg;
    logic [RING_W-1:0] ring_idx_next;
    logic              lock_armed_reg;
    logic [14:0]       lock_count_reg;
    logic [15:0]       lock_compare_reg;
    logic [15:0]       tick_now_reg;
    logic [15:0]       tick_last_reg;
    logic [15:0]       last_j0_reg;

    // datapath
    logic              is_tick;
    logic              is_run_tick;
    logic              lock_armed_eff;
    logic [15:0]       tick_now_eff;
    logic [15:0]       tick_last_eff;
    logic              in_seg;
    logic              lock_hit;
    logic signed [15:0] pos [JOINT_MAX];
    logic [15:0]       joint_cmp [JOINT_MAX];
    logic [15:0]       avg [JOINT_MAX];
    logic [SUM_W-1:0]  sum [JOINT_MAX];
    logic [JOINT_MAX-1:0] mask;
    logic [15:0]       res_cmp [JOINT_MAX];
    logic              homed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= '0;
            mid_reg      <= '0;
            range_reg    <= '0;
            sign_reg     <= '0;
            shift_reg    <= '0;
            freefall_reg <= '0;
            timeout_reg  <= 15'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_SCALE:    scale_reg    <= pwdata[47:0];
                REG_MID:      mid_reg      <= pwdata[47:0];
                REG_RANGE:    range_reg    <= pwdata[47:0];
                REG_SIGN:     sign_reg     <= pwdata[2:0];
                REG_SHIFT:    shift_reg    <= pwdata[4:0];
                REG_FREEFALL: freefall_reg <= pwdata[15:0];
                REG_TIMEOUT:  timeout_reg  <= pwdata[14:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_SCALE:    prdata = PDATA_W'(scale_reg);
            REG_MID:      prdata = PDATA_W'(mid_reg);
            REG_RANGE:    prdata = PDATA_W'(range_reg);
            REG_SIGN:     prdata = PDATA_W'(sign_reg);
            REG_SHIFT:    prdata = PDATA_W'(shift_reg);
            REG_FREEFALL: prdata = PDATA_W'(freefall_reg);
            REG_TIMEOUT:  prdata = PDATA_W'(timeout_reg);
            default:      prdata = '0;
        endcase
    end

    // input register and result register; the result register decouples a stall
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= '{
                req_type:           req_type_t'(s_tuser),
                running:            s_tdata[0],
                lower_switch_level: s_tdata[1],
                seg_load:           s_tdata[2],
                seg_start:          s_tdata[18:3],
                seg_finish:         s_tdata[34:19],
                pos_joint0:         signed'(s_tdata[50:35]),
                pos_joint1:         signed'(s_tdata[66:51]),
                pos_joint2:         signed'(s_tdata[82:67])
            };
        end
        if (advance)
        begin
            out_data_reg <= M_TDATA_W'({homed, res_cmp[2], res_cmp[1], res_cmp[0], mask});
        end
    end

    // request decode and segment window
    assign is_tick        = (in_item_reg.req_type == REQ_TICK);
    assign is_run_tick    = is_tick && in_item_reg.running;
    assign lock_armed_eff = lock_armed_reg && !(is_run_tick && in_item_reg.lower_switch_level);
    assign tick_now_eff   = in_item_reg.seg_load ? in_item_reg.seg_start : tick_now_reg;
    assign tick_last_eff  = in_item_reg.seg_load ? in_item_reg.seg_finish : tick_last_reg;
    assign in_seg         = (tick_now_eff <= tick_last_eff);
    assign homed          = !is_tick && !in_item_reg.running;

    assign pos[0] = in_item_reg.pos_joint0;
    assign pos[1] = in_item_reg.pos_joint1;
    assign pos[2] = in_item_reg.pos_joint2;

    for (genvar j = 0; j < JOINT_MAX; j++)
    begin : g_joint
        if (j < JOINT_COUNT)
        begin : g_on
            joint_cfg_t jcfg;

            assign jcfg = '{
                scale:  scale_reg[16*j +: 16],
                mid:    mid_reg[16*j +: 16],
                range:  range_reg[16*j +: 16],
                negate: sign_reg[j],
                shift:  shift_reg
            };

            scsl_joint u_joint (
                .pos     (pos[j]),
                .cfg     (jcfg),
                .compare (joint_cmp[j])
            );

            // new value takes the place of the slot being overwritten
            always_comb
            begin
                sum[j] = '0;
                for (int k = 0; k < AVG_DEPTH; k++)
                begin
                    if (RING_W'(k) == ring_idx_reg)
                    begin
                        sum[j] = sum[j] + SUM_W'(joint_cmp[j]);
                    end
                    else
                    begin
                        sum[j] = sum[j] + SUM_W'(ring_reg[k][j]);
                    end
                end
                avg[j] = 16'(sum[j] / AVG_DEPTH);
            end
        end
        else
        begin : g_off
            assign joint_cmp[j] = '0;
            assign sum[j]       = '0;
            assign avg[j]       = '0;
        end
    end

    assign lock_hit = lock_armed_eff &&
                      !((lock_count_reg != '0) && (joint_cmp[0] > lock_compare_reg));

    always_comb
    begin
        mask = '0;
        for (int j = 0; j < JOINT_MAX; j++)
        begin
            res_cmp[j] = '0;
        end
        if (is_run_tick)
        begin
            if (in_seg)
            begin
                mask = JOINT_MASK;
                for (int j = 0; j < JOINT_MAX; j++)
                begin
                    res_cmp[j] = avg[j];
                end
                if (lock_hit)
                begin
                    res_cmp[0] = freefall_reg;
                end
            end
            else if (lock_armed_eff)
            begin
                mask       = JOINT_MAX'(1);
                res_cmp[0] = freefall_reg;
            end
        end
    end

    assign ring_idx_next = (ring_idx_reg == RING_W'(AVG_DEPTH - 1)) ? '0 : ring_idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AVG_DEPTH; k++)
            begin
                for (int j = 0; j < JOINT_COUNT; j++)
                begin
                    ring_reg[k][j] <= '0;
                end
            end
            ring_idx_reg     <= '0;
            lock_armed_reg   <= 1'b0;
            lock_count_reg   <= '0;
            lock_compare_reg <= '0;
            tick_now_reg     <= '0;
            tick_last_reg    <= '0;
            last_j0_reg      <= '0;
        end
        else if (advance)
        begin
            if (!is_tick && in_item_reg.running)
            begin
                // arm the lock against the last joint 0 output
                lock_armed_reg   <= 1'b1;
                lock_count_reg   <= timeout_reg;
                lock_compare_reg <= last_j0_reg;
            end
            else if (is_run_tick)
            begin
                lock_armed_reg <= lock_armed_eff;
                tick_last_reg  <= tick_last_eff;
                if (in_seg)
                begin
                    tick_now_reg <= tick_now_eff + 16'd1;
                    ring_idx_reg <= ring_idx_next;
                    last_j0_reg  <= res_cmp[0];
                    for (int j = 0; j < JOINT_COUNT; j++)
                    begin
                        ring_reg[ring_idx_reg][j] <= joint_cmp[j];
                    end
                end
                else
                begin
                    tick_now_reg <= tick_now_eff;
                    if (lock_armed_eff)
                    begin
                        last_j0_reg <= freefall_reg;
                    end
                end
            end
        end
    end

endmodule
